[rtl/lens_distortion_forward_map_defines.svh]
// ---------------------------------------------------------------------------
// lens distortion forward map assertion macros
// clocked assertion wrappers used by the top-level rtl file
// ---------------------------------------------------------------------------
`ifndef LENS_DISTORTION_FORWARD_MAP_DEFINES_SVH
`define LENS_DISTORTION_FORWARD_MAP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LDFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LDFM_ASSERT_IMP(label, ante, cons, msg) \
  `LDFM_ASSERT(label, (ante) |-> (cons), msg)
`define LDFM_ASSERT_NXT(label, ante, cons, msg) \
  `LDFM_ASSERT(label, (ante) |=> (cons), msg)
`else
`define LDFM_ASSERT(label, prop, msg)
`define LDFM_ASSERT_IMP(label, ante, cons, msg)
`define LDFM_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[rtl/ldfm_pkg.sv]
// ---------------------------------------------------------------------------
// ldfm_pkg
// shared types, constants and fixed point helpers of the distortion map
// ---------------------------------------------------------------------------
`default_nettype none
package ldfm_pkg;

  localparam int DIV_BITS = 32;

  localparam logic signed [63:0] Q_ONE64 = 64'sd268435456;
  localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;
  localparam logic signed [63:0] Q_RND64 = 64'sd134217728;
  localparam logic signed [63:0] U_RND64 = 64'sd2147483648;
  localparam logic signed [63:0] PIX_MAX64 = 64'sd131071;
  localparam logic signed [63:0] PIX_MIN64 = -64'sd131072;
  localparam logic signed [31:0] Q_MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN32 = 32'sh80000000;

  typedef enum logic [2:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_PRINCIPAL,
    REG_K1,
    REG_K2,
    REG_K3,
    REG_P1,
    REG_P2
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic clip;
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               ovf;
  } qres_t;

  typedef struct packed {
    logic signed [17:0] v;
    logic               ovf;
  } pres_t;

  function automatic qres_t satq(input logic signed [63:0] a);
    qres_t r;
    if (a > Q_MAX64) begin
      r.v   = Q_MAX32;
      r.ovf = 1'b1;
    end else if (a < Q_MIN64) begin
      r.v   = Q_MIN32;
      r.ovf = 1'b1;
    end else begin
      r.v   = a[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic qres_t mulq(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = 64'(a) * 64'(b);
    s = (p + Q_RND64) >>> 28;
    return satq(s);
  endfunction

  function automatic pres_t sat_pix(input logic signed [63:0] a);
    pres_t r;
    if (a > PIX_MAX64) begin
      r.v   = 18'sh1ffff;
      r.ovf = 1'b1;
    end else if (a < PIX_MIN64) begin
      r.v   = 18'sh20000;
      r.ovf = 1'b1;
    end else begin
      r.v   = a[17:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/ldfm_norm.sv]
// ---------------------------------------------------------------------------
// ldfm_norm
// principal point offset and pipelined restoring division by focal length
// ---------------------------------------------------------------------------
`default_nettype none
module ldfm_norm
  import ldfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [17:0] in_x,
  input  logic signed [17:0] in_y,
  input  logic [15:0]        pp_x,
  input  logic [15:0]        pp_y,
  input  logic [19:0]        focal_x,
  input  logic [19:0]        focal_y,
  output ctl_t               out_ctl,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y
);

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } axis_t;

  logic signed [17:0] coord [2];
  logic [15:0]        pp [2];
  logic [19:0]        fl [2];

  logic [DIV_BITS+2:0] v_r;
  logic signed [18:0]  d_r [2];
  logic [49:0]         rem_r [2][DIV_BITS+1];
  logic [31:0]         q_r [2][DIV_BITS+1];
  axis_t               st_r [2][DIV_BITS+1];
  logic signed [31:0]  res_r [2];
  logic                clip_r [2];

  assign coord[0] = in_x;
  assign coord[1] = in_y;
  assign pp[0]    = pp_x;
  assign pp[1]    = pp_y;
  assign fl[0]    = focal_x;
  assign fl[1]    = focal_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_BITS+1:0], in_valid};
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic [18:0] mag;
    logic [49:0] num;
    axis_t       st_b;
    logic signed [31:0] res;
    logic        clip;

    always_comb begin
      st_b.neg  = d_r[ax][18];
      st_b.zero = (d_r[ax] == 19'sd0);
      mag       = st_b.neg ? 19'(-d_r[ax]) : 19'(d_r[ax]);
      num       = {mag[17:0], 32'd0} + 50'(fl[ax] >> 1);
      st_b.ovf  = {2'b00, num} >= {fl[ax], 32'd0};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[ax]      <= $signed({coord[ax][17], coord[ax]}) - $signed({3'b000, pp[ax]});
        rem_r[ax][0] <= num;
        q_r[ax][0]   <= '0;
        st_r[ax][0]  <= st_b;
      end
    end

    for (genvar s = 0; s < DIV_BITS; s++) begin : g_step
      localparam int SH = DIV_BITS - 1 - s;
      logic [51:0] dvs;
      logic        ge;
      always_comb begin
        dvs = 52'(fl[ax]) << SH;
        ge  = {2'b00, rem_r[ax][s]} >= dvs;
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[ax][s+1] <= ge ? (rem_r[ax][s] - dvs[49:0]) : rem_r[ax][s];
          q_r[ax][s+1]   <= {q_r[ax][s][30:0], ge};
          st_r[ax][s+1]  <= st_r[ax][s];
        end
      end
    end

    always_comb begin
      clip = 1'b0;
      res  = '0;
      if (st_r[ax][DIV_BITS].zero) begin
        res = '0;
      end else if (st_r[ax][DIV_BITS].ovf) begin
        clip = 1'b1;
        res  = st_r[ax][DIV_BITS].neg ? Q_MIN32 : Q_MAX32;
      end else if (!st_r[ax][DIV_BITS].neg) begin
        if (q_r[ax][DIV_BITS][31]) begin
          clip = 1'b1;
          res  = Q_MAX32;
        end else begin
          res = $signed(q_r[ax][DIV_BITS]);
        end
      end else if (q_r[ax][DIV_BITS] > 32'h80000000) begin
        clip = 1'b1;
        res  = Q_MIN32;
      end else begin
        res = $signed(32'(-q_r[ax][DIV_BITS]));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[ax]  <= res;
        clip_r[ax] <= clip;
      end
    end
  end

  assign out_ctl.valid = v_r[DIV_BITS+2];
  assign out_ctl.clip  = clip_r[0] | clip_r[1];
  assign out_x         = res_r[0];
  assign out_y         = res_r[1];

endmodule
`default_nettype wire

[rtl/ldfm_poly.sv]
// ---------------------------------------------------------------------------
// ldfm_poly
// radial and tangential distortion polynomial, eight register stages
// ---------------------------------------------------------------------------
`default_nettype none
module ldfm_poly
  import ldfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ctl_t               in_ctl,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] k1,
  input  logic signed [31:0] k2,
  input  logic signed [31:0] k3,
  input  logic signed [31:0] p1,
  input  logic signed [31:0] p2,
  output ctl_t               out_ctl,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y
);

  ctl_t c_r [8];
  ctl_t c_nxt [8];

  logic signed [31:0] s1_x2_r, s1_y2_r, s1_xy_r, s1_x_r, s1_y_r;
  logic signed [31:0] s2_r2_r, s2_a_r, s2_b_r, s2_xy_r, s2_x_r, s2_y_r;
  logic signed [31:0] s3_r4_r, s3_r2_r, s3_k1r2_r, s3_p1xy_r, s3_p2xy_r;
  logic signed [31:0] s3_p2a_r, s3_p1b_r, s3_x_r, s3_y_r;
  logic signed [31:0] s4_r6_r, s4_k2r4_r, s4_k1r2_r, s4_x_r, s4_y_r;
  logic signed [34:0] s4_tx_r, s4_ty_r;
  logic signed [31:0] s5_k3r6_r, s5_k1r2_r, s5_k2r4_r, s5_x_r, s5_y_r;
  logic signed [34:0] s5_tx_r, s5_ty_r;
  logic signed [31:0] s6_rad_r, s6_x_r, s6_y_r;
  logic signed [34:0] s6_tx_r, s6_ty_r;
  logic signed [31:0] s7_mx_r, s7_my_r;
  logic signed [34:0] s7_tx_r, s7_ty_r;
  logic signed [31:0] s8_xd_r, s8_yd_r;

  qres_t m_x2, m_y2, m_xy;
  qres_t q_r2, q_a, q_b;
  qres_t m_r4, m_k1r2, m_p1xy, m_p2xy, m_p2a, m_p1b;
  qres_t m_r6, m_k2r4;
  logic signed [34:0] tx_nxt, ty_nxt;
  qres_t m_k3r6, q_rad, m_mx, m_my, q_xd, q_yd;

  always_comb begin
    m_x2 = mulq(in_x, in_x);
    m_y2 = mulq(in_y, in_y);
    m_xy = mulq(in_x, in_y);
    c_nxt[0].valid = in_ctl.valid;
    c_nxt[0].clip  = in_ctl.clip | m_x2.ovf | m_y2.ovf | m_xy.ovf;

    q_r2 = satq(64'(s1_x2_r) + 64'(s1_y2_r));
    q_a  = satq(64'(q_r2.v) + 64'(s1_x2_r) + 64'(s1_x2_r));
    q_b  = satq(64'(q_r2.v) + 64'(s1_y2_r) + 64'(s1_y2_r));
    c_nxt[1].valid = c_r[0].valid;
    c_nxt[1].clip  = c_r[0].clip | q_r2.ovf | q_a.ovf | q_b.ovf;

    m_r4   = mulq(s2_r2_r, s2_r2_r);
    m_k1r2 = mulq(k1, s2_r2_r);
    m_p1xy = mulq(p1, s2_xy_r);
    m_p2xy = mulq(p2, s2_xy_r);
    m_p2a  = mulq(p2, s2_a_r);
    m_p1b  = mulq(p1, s2_b_r);
    c_nxt[2].valid = c_r[1].valid;
    c_nxt[2].clip  = c_r[1].clip | m_r4.ovf | m_k1r2.ovf | m_p1xy.ovf | m_p2xy.ovf
                   | m_p2a.ovf | m_p1b.ovf;

    m_r6   = mulq(s3_r4_r, s3_r2_r);
    m_k2r4 = mulq(k2, s3_r4_r);
    tx_nxt = (35'(s3_p1xy_r) <<< 1) + 35'(s3_p2a_r);
    ty_nxt = 35'(s3_p1b_r) + (35'(s3_p2xy_r) <<< 1);
    c_nxt[3].valid = c_r[2].valid;
    c_nxt[3].clip  = c_r[2].clip | m_r6.ovf | m_k2r4.ovf;

    m_k3r6 = mulq(k3, s4_r6_r);
    c_nxt[4].valid = c_r[3].valid;
    c_nxt[4].clip  = c_r[3].clip | m_k3r6.ovf;

    q_rad = satq(Q_ONE64 + 64'(s5_k1r2_r) + 64'(s5_k2r4_r) + 64'(s5_k3r6_r));
    c_nxt[5].valid = c_r[4].valid;
    c_nxt[5].clip  = c_r[4].clip | q_rad.ovf;

    m_mx = mulq(s6_x_r, s6_rad_r);
    m_my = mulq(s6_y_r, s6_rad_r);
    c_nxt[6].valid = c_r[5].valid;
    c_nxt[6].clip  = c_r[5].clip | m_mx.ovf | m_my.ovf;

    q_xd = satq(64'(s7_mx_r) + 64'(s7_tx_r));
    q_yd = satq(64'(s7_my_r) + 64'(s7_ty_r));
    c_nxt[7].valid = c_r[6].valid;
    c_nxt[7].clip  = c_r[6].clip | q_xd.ovf | q_yd.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        c_r[i] <= '0;
      end
    end else if (en) begin
      for (int i = 0; i < 8; i++) begin
        c_r[i] <= c_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x2_r   <= m_x2.v;
      s1_y2_r   <= m_y2.v;
      s1_xy_r   <= m_xy.v;
      s1_x_r    <= in_x;
      s1_y_r    <= in_y;
      s2_r2_r   <= q_r2.v;
      s2_a_r    <= q_a.v;
      s2_b_r    <= q_b.v;
      s2_xy_r   <= s1_xy_r;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s3_r4_r   <= m_r4.v;
      s3_r2_r   <= s2_r2_r;
      s3_k1r2_r <= m_k1r2.v;
      s3_p1xy_r <= m_p1xy.v;
      s3_p2xy_r <= m_p2xy.v;
      s3_p2a_r  <= m_p2a.v;
      s3_p1b_r  <= m_p1b.v;
      s3_x_r    <= s2_x_r;
      s3_y_r    <= s2_y_r;
      s4_r6_r   <= m_r6.v;
      s4_k2r4_r <= m_k2r4.v;
      s4_k1r2_r <= s3_k1r2_r;
      s4_tx_r   <= tx_nxt;
      s4_ty_r   <= ty_nxt;
      s4_x_r    <= s3_x_r;
      s4_y_r    <= s3_y_r;
      s5_k3r6_r <= m_k3r6.v;
      s5_k1r2_r <= s4_k1r2_r;
      s5_k2r4_r <= s4_k2r4_r;
      s5_tx_r   <= s4_tx_r;
      s5_ty_r   <= s4_ty_r;
      s5_x_r    <= s4_x_r;
      s5_y_r    <= s4_y_r;
      s6_rad_r  <= q_rad.v;
      s6_tx_r   <= s5_tx_r;
      s6_ty_r   <= s5_ty_r;
      s6_x_r    <= s5_x_r;
      s6_y_r    <= s5_y_r;
      s7_mx_r   <= m_mx.v;
      s7_my_r   <= m_my.v;
      s7_tx_r   <= s6_tx_r;
      s7_ty_r   <= s6_ty_r;
      s8_xd_r   <= q_xd.v;
      s8_yd_r   <= q_yd.v;
    end
  end

  assign out_ctl = c_r[7];
  assign out_x   = s8_xd_r;
  assign out_y   = s8_yd_r;

endmodule
`default_nettype wire

[rtl/ldfm_unmap.sv]
// ---------------------------------------------------------------------------
// ldfm_unmap
// scale back by focal length, add principal point, saturate to pixels
// ---------------------------------------------------------------------------
`default_nettype none
module ldfm_unmap
  import ldfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ctl_t               in_ctl,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic [19:0]        focal_x,
  input  logic [19:0]        focal_y,
  input  logic [15:0]        pp_x,
  input  logic [15:0]        pp_y,
  output ctl_t               out_ctl,
  output logic signed [17:0] out_x,
  output logic signed [17:0] out_y
);

  ctl_t               c1_r, c2_r;
  logic signed [52:0] px_r, py_r;
  logic signed [17:0] wx_r, wy_r;
  logic signed [63:0] tx, ty;
  pres_t              sx, sy;

  always_comb begin
    tx = ((64'(px_r) + U_RND64) >>> 32) + $signed({48'd0, pp_x});
    ty = ((64'(py_r) + U_RND64) >>> 32) + $signed({48'd0, pp_y});
    sx = sat_pix(tx);
    sy = sat_pix(ty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
    end else if (en) begin
      c1_r       <= in_ctl;
      c2_r.valid <= c1_r.valid;
      c2_r.clip  <= c1_r.clip | sx.ovf | sy.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 53'(in_x) * 53'($signed({1'b0, focal_x}));
      py_r <= 53'(in_y) * 53'($signed({1'b0, focal_y}));
      wx_r <= sx.v;
      wy_r <= sy.v;
    end
  end

  assign out_ctl = c2_r;
  assign out_x   = wx_r;
  assign out_y   = wy_r;

endmodule
`default_nettype wire

[rtl/lens_distortion_forward_map.sv]
// ---------------------------------------------------------------------------
// lens_distortion_forward_map
// brown-conrady forward lens distortion of pixel coordinates, fully pipelined
//
//   channel   ports   direction   contents
//   input     in_*    slave       ideal_x, ideal_y per transfer
//   output    out_*   master      warped_x, warped_y, clipped per transfer
//   config    cfg_*   apb slave   eight configuration registers
//
// one transfer per cycle sustained while the output does not stall; the depth
// of the pipeline is set mostly by the 32 one-bit focal length divider stages
// a two-entry output register and skid let the pipeline keep moving while a
// result waits; once a second result arrives in_tready drops and all stages hold
// synchronous active-low reset clears valid bits and loads register defaults
// ---------------------------------------------------------------------------
`default_nettype none
`include "lens_distortion_forward_map_defines.svh"
module lens_distortion_forward_map
  import ldfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // ideal_x, ideal_y, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // warped_x, warped_y, zero fill
  output logic        out_tuser,   // clipped
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic               clip;
  } item_t;

  logic [19:0]        focal_x_r, focal_y_r;
  logic [31:0]        pp_r;
  logic signed [31:0] k1_r, k2_r, k3_r, p1_r, p2_r;

  logic               en;
  ctl_t               n_ctl, p_ctl, u_ctl;
  logic signed [31:0] n_x, n_y, p_x, p_y;
  logic signed [17:0] u_x, u_y;
  item_t              pipe_item;
  item_t              out_r, skid_r;
  logic               out_v_r, skid_v_r;
  logic               wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r <= 20'd256000;
      focal_y_r <= 20'd256000;
      pp_r      <= '0;
      k1_r      <= '0;
      k2_r      <= '0;
      k3_r      <= '0;
      p1_r      <= '0;
      p2_r      <= '0;
    end else if (wr) begin
      case (cfg_reg_e'(cfg_paddr[4:2]))
        REG_FOCAL_X:   focal_x_r <= cfg_pwdata[19:0];
        REG_FOCAL_Y:   focal_y_r <= cfg_pwdata[19:0];
        REG_PRINCIPAL: pp_r      <= cfg_pwdata;
        REG_K1:        k1_r      <= cfg_pwdata;
        REG_K2:        k2_r      <= cfg_pwdata;
        REG_K3:        k3_r      <= cfg_pwdata;
        REG_P1:        p1_r      <= cfg_pwdata;
        REG_P2:        p2_r      <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(cfg_paddr[4:2]))
      REG_FOCAL_X:   cfg_prdata = {12'd0, focal_x_r};
      REG_FOCAL_Y:   cfg_prdata = {12'd0, focal_y_r};
      REG_PRINCIPAL: cfg_prdata = pp_r;
      REG_K1:        cfg_prdata = k1_r;
      REG_K2:        cfg_prdata = k2_r;
      REG_K3:        cfg_prdata = k3_r;
      REG_P1:        cfg_prdata = p1_r;
      REG_P2:        cfg_prdata = p2_r;
      default:       cfg_prdata = '0;
    endcase
  end

  assign en        = ~skid_v_r;
  assign in_tready = en;

  ldfm_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_x     ($signed(in_tdata[17:0])),
    .in_y     ($signed(in_tdata[35:18])),
    .pp_x     (pp_r[15:0]),
    .pp_y     (pp_r[31:16]),
    .focal_x  (focal_x_r),
    .focal_y  (focal_y_r),
    .out_ctl  (n_ctl),
    .out_x    (n_x),
    .out_y    (n_y)
  );

  ldfm_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (n_ctl),
    .in_x    (n_x),
    .in_y    (n_y),
    .k1      (k1_r),
    .k2      (k2_r),
    .k3      (k3_r),
    .p1      (p1_r),
    .p2      (p2_r),
    .out_ctl (p_ctl),
    .out_x   (p_x),
    .out_y   (p_y)
  );

  ldfm_unmap u_unmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (p_ctl),
    .in_x    (p_x),
    .in_y    (p_y),
    .focal_x (focal_x_r),
    .focal_y (focal_y_r),
    .pp_x    (pp_r[15:0]),
    .pp_y    (pp_r[31:16]),
    .out_ctl (u_ctl),
    .out_x   (u_x),
    .out_y   (u_y)
  );

  assign pipe_item.x    = u_x;
  assign pipe_item.y    = u_y;
  assign pipe_item.clip = u_ctl.clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      out_v_r  <= skid_v_r | u_ctl.valid;
      skid_v_r <= 1'b0;
    end else if (u_ctl.valid && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      out_r <= skid_v_r ? skid_r : pipe_item;
    end else if (u_ctl.valid && !skid_v_r) begin
      skid_r <= pipe_item;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_r.y, out_r.x};
  assign out_tuser  = out_r.clip;

  // skid only ever holds a result behind a waiting output register
  `LDFM_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r, "skid full with output empty")
  `LDFM_ASSERT_IMP(a_skid_fill, $rose(skid_v_r), $past(out_v_r && !out_tready),
                   "skid filled without output stall")
  `LDFM_ASSERT_NXT(a_skid_drain, skid_v_r && out_tready, !skid_v_r, "skid did not drain")
  `LDFM_ASSERT_NXT(a_skid_catch, out_v_r && !out_tready && !skid_v_r && u_ctl.valid,
                   skid_v_r, "pipeline result dropped on stall")

endmodule
`default_nettype wire
